// ===== rtl/mf3_pkg.sv =====
// ============================================================================
// mf3_pkg
// Shared types and constants for the 3x3 median filter stream block: payload
// structs, configuration register codes and the column slice type.
// ============================================================================
package mf3_pkg;

    localparam int PIXEL_BITS     = 8;
    localparam int POS_BITS       = 12;
    localparam int CFG_DATA_BITS  = 13;
    localparam int CFG_INDEX_BITS = 1;

    localparam logic [PIXEL_BITS-1:0] BORDER_VALUE = 8'd255;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] pixel_in;
        logic                  frame_start;
    } pix_in_t;

    typedef struct packed {
        logic [POS_BITS-1:0]   out_row;
        logic [POS_BITS-1:0]   out_col;
        logic [PIXEL_BITS-1:0] out_pixel;
        logic                  last_of_run;
    } pix_out_t;

    // One pending result without its run marker
    typedef struct packed {
        logic [POS_BITS-1:0]   row;
        logic [POS_BITS-1:0]   col;
        logic [PIXEL_BITS-1:0] pixel;
    } result_t;

    // Three pixels of one window column, sorted ascending
    typedef struct packed {
        logic [PIXEL_BITS-1:0] lo;
        logic [PIXEL_BITS-1:0] md;
        logic [PIXEL_BITS-1:0] hi;
    } column_t;

endpackage

// ===== rtl/mf3_line_ram.sv =====
// ============================================================================
// mf3_line_ram
// One line store: simple dual-port RAM with registered, read-first output.
// ============================================================================
module mf3_line_ram #(
    parameter int DEPTH     = 4096,
    parameter int DATA_BITS = 8,
    parameter int ADDR_BITS = 12
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [DATA_BITS-1:0] wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [DATA_BITS-1:0] rd_data
);

    logic [DATA_BITS-1:0] mem [DEPTH];
    logic [DATA_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/mf3_median.sv =====
// ============================================================================
// mf3_median
// Sort the newest column slice and take the median of the 3x3 window from
// three sorted columns (max of lows, median of middles, min of highs).
// ============================================================================
module mf3_median (
    input  logic [mf3_pkg::PIXEL_BITS-1:0] up,
    input  logic [mf3_pkg::PIXEL_BITS-1:0] mid,
    input  logic [mf3_pkg::PIXEL_BITS-1:0] pix,
    input  mf3_pkg::column_t               win_old,
    input  mf3_pkg::column_t               win_new,
    output mf3_pkg::column_t               cur_sorted,
    output logic [mf3_pkg::PIXEL_BITS-1:0] median
);

    import mf3_pkg::*;

    function automatic logic [PIXEL_BITS-1:0] max2(input logic [PIXEL_BITS-1:0] a,
                                                   input logic [PIXEL_BITS-1:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic [PIXEL_BITS-1:0] min2(input logic [PIXEL_BITS-1:0] a,
                                                   input logic [PIXEL_BITS-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [PIXEL_BITS-1:0] med3(input logic [PIXEL_BITS-1:0] a,
                                                   input logic [PIXEL_BITS-1:0] b,
                                                   input logic [PIXEL_BITS-1:0] c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    logic [PIXEL_BITS-1:0] low_max;
    logic [PIXEL_BITS-1:0] mid_med;
    logic [PIXEL_BITS-1:0] high_min;

    always_comb
    begin
        cur_sorted.lo = min2(min2(up, mid), pix);
        cur_sorted.md = med3(up, mid, pix);
        cur_sorted.hi = max2(max2(up, mid), pix);

        low_max  = max2(max2(win_old.lo, win_new.lo), cur_sorted.lo);
        mid_med  = med3(win_old.md, win_new.md, cur_sorted.md);
        high_min = min2(min2(win_old.hi, win_new.hi), cur_sorted.hi);
        median   = med3(low_max, mid_med, high_min);
    end

endmodule

// ===== rtl/mf3_res_buf.sv =====
// ============================================================================
// mf3_res_buf
// Result register: hold up to three results of one pixel and hand them out
// one transfer per cycle while res_stall is low, marking the last one of the run.
// ============================================================================
module mf3_res_buf (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  logic [2:0]             load_mask,
    input  mf3_pkg::result_t [2:0] load_res,
    output logic                   free,
    output logic                   res_valid,
    input  logic                   res_stall,
    output mf3_pkg::pix_out_t      res_data
);

    import mf3_pkg::*;

    result_t [2:0] slot_reg;
    logic [2:0]    pend_reg;
    logic [2:0]    pend_next;
    logic [2:0]    remain;
    logic          xfer;
    result_t       head;

    always_comb
    begin
        // Clear the lowest pending bit: what is left after this transfer
        remain    = pend_reg & (pend_reg - 3'd1);
        res_valid = (pend_reg != 3'd0);
        xfer      = res_valid && !res_stall;
        free      = (pend_reg == 3'd0) || (xfer && (remain == 3'd0));

        if (pend_reg[0])
        begin
            head = slot_reg[0];
        end
        else if (pend_reg[1])
        begin
            head = slot_reg[1];
        end
        else
        begin
            head = slot_reg[2];
        end

        res_data.out_row     = head.row;
        res_data.out_col     = head.col;
        res_data.out_pixel   = head.pixel;
        res_data.last_of_run = (remain == 3'd0);

        pend_next = pend_reg;
        if (load)
        begin
            pend_next = load_mask;
        end
        else if (xfer)
        begin
            pend_next = remain;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 3'd0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            slot_reg <= load_res;
        end
    end

endmodule

// ===== rtl/median_filter_3x3_stream.sv =====
// ============================================================================
// median_filter_3x3_stream
// 3x3 median filter over a raster-order grey pixel stream with row/column
// tagged results and a fixed border value.
// ============================================================================
// Pixels enter in raster order, one transfer per cycle unless pix_stall holds
// them. Each pixel (r,c) releases the result for (r-1,c-1) when r and c are
// both at least one: the median of its 3x3 neighborhood for interior
// positions, 255 on the border. The last pixel of a row also releases
// (r-1,W-1), and every pixel of the bottom row releases itself as 255, so
// each frame position comes out once. A pixel with frame_start set is taken
// as position (0,0). The result register drains one result per cycle while
// res_stall is low, so a pixel that releases two or three results keeps the
// input stalled while its further results drain. A pixel goes through the
// line store read stage, then the compare network into the result register.
// Frame size registers are clamped to [3, MAX_WIDTH] and [3, MAX_HEIGHT] as
// they are written; write them only while the block is idle. The line stores
// are not cleared after reset: the first two rows of a frame never show data
// read from them.
module median_filter_3x3_stream #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // pixel input channel
    input  logic                                pix_valid,
    output logic                                pix_stall,
    input  mf3_pkg::pix_in_t                    pix_data,
    // result channel
    output logic                                res_valid,
    input  logic                                res_stall,
    output mf3_pkg::pix_out_t                   res_data,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mf3_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [mf3_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    import mf3_pkg::*;

    localparam int COL_BITS = $clog2(MAX_WIDTH);
    localparam int ROW_BITS = $clog2(MAX_HEIGHT);
    localparam int W_BITS   = $clog2(MAX_WIDTH + 1);
    localparam int H_BITS   = $clog2(MAX_HEIGHT + 1);
    localparam int CMP_A    = (W_BITS > H_BITS) ? W_BITS : H_BITS;
    localparam int CMP_BITS = (CMP_A > CFG_DATA_BITS) ? CMP_A : CFG_DATA_BITS;
    localparam int RESET_W  = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
    localparam int RESET_H  = (480 > MAX_HEIGHT) ? MAX_HEIGHT : 480;
    localparam int MIN_DIM  = 3;

    // ------------------------------------------------------------------
    // Frame size registers, stored clamped, plus last index for each
    // ------------------------------------------------------------------
    logic [W_BITS-1:0]   wlim_reg;
    logic [COL_BITS-1:0] wm1_reg;
    logic [H_BITS-1:0]   hlim_reg;
    logic [ROW_BITS-1:0] hm1_reg;
    logic [CMP_BITS-1:0] cfg_wide;
    logic [CMP_BITS-1:0] w_clamped;
    logic [CMP_BITS-1:0] h_clamped;
    logic                cfg_xfer;

    assign cfg_ready = 1'b1;
    assign cfg_xfer  = cfg_valid && cfg_ready;

    always_comb
    begin
        cfg_wide = CMP_BITS'(cfg_data);
        if (cfg_wide < CMP_BITS'(MIN_DIM))
        begin
            w_clamped = CMP_BITS'(MIN_DIM);
        end
        else if (cfg_wide > CMP_BITS'(MAX_WIDTH))
        begin
            w_clamped = CMP_BITS'(MAX_WIDTH);
        end
        else
        begin
            w_clamped = cfg_wide;
        end
        if (cfg_wide < CMP_BITS'(MIN_DIM))
        begin
            h_clamped = CMP_BITS'(MIN_DIM);
        end
        else if (cfg_wide > CMP_BITS'(MAX_HEIGHT))
        begin
            h_clamped = CMP_BITS'(MAX_HEIGHT);
        end
        else
        begin
            h_clamped = cfg_wide;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlim_reg <= W_BITS'(RESET_W);
            wm1_reg  <= COL_BITS'(RESET_W - 1);
            hlim_reg <= H_BITS'(RESET_H);
            hm1_reg  <= ROW_BITS'(RESET_H - 1);
        end
        else if (cfg_xfer)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_FRAME_WIDTH:
                begin
                    wlim_reg <= W_BITS'(w_clamped);
                    wm1_reg  <= COL_BITS'(w_clamped - CMP_BITS'(1));
                end
                CFG_FRAME_HEIGHT:
                begin
                    hlim_reg <= H_BITS'(h_clamped);
                    hm1_reg  <= ROW_BITS'(h_clamped - CMP_BITS'(1));
                end
                default:
                begin
                    wlim_reg <= wlim_reg;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input side: position counters and line store reads
    // ------------------------------------------------------------------
    logic                  pix_xfer;
    logic                  s1_adv;
    logic                  buf_free;

    logic [COL_BITS-1:0]   col_reg;
    logic [ROW_BITS-1:0]   row_reg;
    logic [COL_BITS-1:0]   col_eff;
    logic [ROW_BITS-1:0]   row_eff;
    logic                  col_last;
    logic                  row_last;
    logic [COL_BITS-1:0]   col_next;
    logic [ROW_BITS-1:0]   row_next;

    logic                  s1_valid_reg;
    logic [PIXEL_BITS-1:0] s1_pix_reg;
    logic [COL_BITS-1:0]   s1_col_reg;
    logic [ROW_BITS-1:0]   s1_row_reg;
    logic [2:0]            s1_mask_reg;
    logic                  s1_med_reg;
    logic                  byp_hit_reg;
    logic [PIXEL_BITS-1:0] byp_data_reg;

    logic [PIXEL_BITS-1:0] up_q;
    logic [PIXEL_BITS-1:0] mid_q;

    assign pix_stall = s1_valid_reg && !buf_free;
    assign pix_xfer  = pix_valid && !pix_stall;
    assign s1_adv    = s1_valid_reg && buf_free;

    always_comb
    begin
        // Wrap a counter that sits outside the frame, and restart on frame_start
        if (pix_data.frame_start || (W_BITS'(col_reg) >= wlim_reg))
        begin
            col_eff = '0;
        end
        else
        begin
            col_eff = col_reg;
        end
        if (pix_data.frame_start || (H_BITS'(row_reg) >= hlim_reg))
        begin
            row_eff = '0;
        end
        else
        begin
            row_eff = row_reg;
        end

        col_last = (col_eff == wm1_reg);
        row_last = (row_eff == hm1_reg);

        if (col_last)
        begin
            col_next = '0;
            row_next = row_last ? '0 : row_eff + ROW_BITS'(1);
        end
        else
        begin
            col_next = col_eff + COL_BITS'(1);
            row_next = row_eff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (pix_xfer)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (pix_xfer)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_xfer)
        begin
            s1_pix_reg     <= pix_data.pixel_in;
            s1_col_reg     <= col_eff;
            s1_row_reg     <= row_eff;
            // bit 0: window center, bit 1: end of previous row, bit 2: bottom row
            s1_mask_reg[0] <= (row_eff != '0) && (col_eff != '0);
            s1_mask_reg[1] <= (row_eff != '0) && col_last;
            s1_mask_reg[2] <= row_last;
            s1_med_reg     <= (row_eff >= ROW_BITS'(2)) && (col_eff >= COL_BITS'(2));
            // Forward the upper store write that lands in this same cycle
            byp_hit_reg    <= s1_adv && (col_eff == s1_col_reg);
            byp_data_reg   <= mid_q;
        end
    end

    // Row r-1: written with the new pixel as it is read (read-first)
    mf3_line_ram #(
        .DEPTH     (MAX_WIDTH),
        .DATA_BITS (PIXEL_BITS),
        .ADDR_BITS (COL_BITS)
    ) u_line_mid (
        .clk     (clk),
        .wr_en   (pix_xfer),
        .wr_addr (col_eff),
        .wr_data (pix_data.pixel_in),
        .rd_en   (pix_xfer),
        .rd_addr (col_eff),
        .rd_data (mid_q)
    );

    // Row r-2: takes the old row r-1 pixel once the item leaves the compare stage
    mf3_line_ram #(
        .DEPTH     (MAX_WIDTH),
        .DATA_BITS (PIXEL_BITS),
        .ADDR_BITS (COL_BITS)
    ) u_line_up (
        .clk     (clk),
        .wr_en   (s1_adv),
        .wr_addr (s1_col_reg),
        .wr_data (mid_q),
        .rd_en   (pix_xfer),
        .rd_addr (col_eff),
        .rd_data (up_q)
    );

    // ------------------------------------------------------------------
    // Compare stage: window of sorted columns and the median network
    // ------------------------------------------------------------------
    column_t               win_old_reg;
    column_t               win_new_reg;
    column_t               cur_sorted;
    logic [PIXEL_BITS-1:0] up_val;
    logic [PIXEL_BITS-1:0] median;
    result_t [2:0]         cand;

    assign up_val = byp_hit_reg ? byp_data_reg : up_q;

    mf3_median u_median (
        .up         (up_val),
        .mid        (mid_q),
        .pix        (s1_pix_reg),
        .win_old    (win_old_reg),
        .win_new    (win_new_reg),
        .cur_sorted (cur_sorted),
        .median     (median)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_old_reg <= '0;
            win_new_reg <= '0;
        end
        else if (s1_adv)
        begin
            win_old_reg <= win_new_reg;
            win_new_reg <= cur_sorted;
        end
    end

    always_comb
    begin
        cand[0].row   = POS_BITS'(s1_row_reg - ROW_BITS'(1));
        cand[0].col   = POS_BITS'(s1_col_reg - COL_BITS'(1));
        cand[0].pixel = s1_med_reg ? median : BORDER_VALUE;
        cand[1].row   = POS_BITS'(s1_row_reg - ROW_BITS'(1));
        cand[1].col   = POS_BITS'(wm1_reg);
        cand[1].pixel = BORDER_VALUE;
        cand[2].row   = POS_BITS'(s1_row_reg);
        cand[2].col   = POS_BITS'(s1_col_reg);
        cand[2].pixel = BORDER_VALUE;
    end

    // ------------------------------------------------------------------
    // Result register: while res_stall is low, drain one transfer per cycle
    // ------------------------------------------------------------------
    mf3_res_buf u_res_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (s1_adv),
        .load_mask (s1_mask_reg),
        .load_res  (cand),
        .free      (buf_free),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

`ifndef SYNTHESIS
    // An empty compare stage never holds off the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> !pix_stall)
        else $error("input stalled with empty compare stage");

    // A transfer that is not the last of its run leaves more results pending
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_stall && !res_data.last_of_run) |=> res_valid)
        else $error("run ended without last_of_run");

    // A frame start places the pixel at the origin
    assert property (@(posedge clk) disable iff (!rst_n)
        (pix_xfer && pix_data.frame_start) |=>
            (s1_row_reg == '0) && (s1_col_reg == '0))
        else $error("frame start did not restart position");

    // The forwarding path only fires when the compare stage moved on
    assert property (@(posedge clk) disable iff (!rst_n)
        ($past(pix_xfer) && byp_hit_reg) |-> $past(s1_adv))
        else $error("upper line store forwarded without a write");
`endif

endmodule

// ===== test/testbench.sv =====
// ============================================================================
// testbench
// Stream check of the 3x3 median filter. A built-in model of the line
// stores, the window and the position counters predicts every tagged result;
// the results are checked in order while both channels idle at random.
// ============================================================================
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mf3_pkg::*;

    localparam int LINE_DEPTH    = 4096;   // widest frame the block takes
    localparam int ROWS_MAX      = 4096;   // tallest frame the block takes
    localparam int RESET_CYCLES  = 10;
    localparam int SETTLE_CYCLES = 8;      // covers the result latency
    localparam int IDLE_LIMIT    = 2000;   // cycles without any transfer
    localparam int REPORT_LIMIT  = 10;

    // Receiver stall styles
    typedef enum int {
        STALL_NONE,
        STALL_RANDOM,
        STALL_COMB,
        STALL_LONG
    } stall_style_t;

    // Pixel value styles for random content
    typedef enum int {
        PIX_UNIFORM,
        PIX_CLUSTER,
        PIX_EXTREME
    } pixel_style_t;

    // ------------------------------------------------------------------------
    // Block signals; every input has a known value from time zero
    // ------------------------------------------------------------------------
    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      pix_valid = 1'b0;
    logic                      pix_stall;
    pix_in_t                   pix_data  = '0;
    logic                      res_valid;
    logic                      res_stall = 1'b0;
    pix_out_t                  res_data;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

    median_filter_3x3_stream dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix_data  (pix_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 20 ns period
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Filter model state: two previous rows, two previous column slices,
    // raster position and the raw register values (clamped at use)
    // ------------------------------------------------------------------------
    logic [PIXEL_BITS-1:0] upper_line  [LINE_DEPTH];
    logic [PIXEL_BITS-1:0] middle_line [LINE_DEPTH];
    logic [PIXEL_BITS-1:0] window_pix  [6];
    int                    cur_row    = 0;
    int                    cur_col    = 0;
    int                    width_raw  = 640;
    int                    height_raw = 480;

    pix_in_t  pixel_queue[$];       // pixels waiting for the driver
    pix_out_t expected_pixels[$];   // tagged results still to come out

    int   mismatches  = 0;
    int   idle_cycles = 0;
    logic pix_fire    = 1'b0;       // a pixel transfer happened at the last rising edge

    function automatic int clamp_size(int raw, int top);
        if (raw < 3)
            return 3;
        if (raw > top)
            return top;
        return raw;
    endfunction

    // Fifth smallest of nine, by a plain bubble sort
    function automatic logic [PIXEL_BITS-1:0] median_of_nine(logic [PIXEL_BITS-1:0] v [9]);
        logic [PIXEL_BITS-1:0] s [9];
        logic [PIXEL_BITS-1:0] t;
        s = v;
        for (int i = 0; i < 8; i++)
        begin
            for (int j = 0; j < 8 - i; j++)
            begin
                if (s[j] > s[j+1])
                begin
                    t      = s[j];
                    s[j]   = s[j+1];
                    s[j+1] = t;
                end
            end
        end
        return s[4];
    endfunction

    function automatic pix_out_t position_result(int r, int c, logic [PIXEL_BITS-1:0] value);
        pix_out_t res;
        res.out_row     = POS_BITS'(r);
        res.out_col     = POS_BITS'(c);
        res.out_pixel   = value;
        res.last_of_run = 1'b0;
        return res;
    endfunction

    // Advance the filter model by one pixel and queue the results it releases
    function automatic void predict_pixel(pix_in_t item);
        int                    w;
        int                    h;
        int                    r;
        int                    c;
        int                    n;
        logic [PIXEL_BITS-1:0] up;
        logic [PIXEL_BITS-1:0] mid;
        logic [PIXEL_BITS-1:0] val;
        logic [PIXEL_BITS-1:0] hood [9];
        pix_out_t              run [3];

        w = clamp_size(width_raw, LINE_DEPTH);
        h = clamp_size(height_raw, ROWS_MAX);
        n = 0;

        // Frame start forces (0,0); a position left outside a shrunk frame wraps to 0
        if (item.frame_start)
        begin
            cur_row = 0;
            cur_col = 0;
        end
        if (cur_col >= w)
            cur_col = 0;
        if (cur_row >= h)
            cur_row = 0;
        r   = cur_row;
        c   = cur_col;
        up  = upper_line[c];
        mid = middle_line[c];

        // Up-left neighbor: median inside, border value on the first row/column
        if (r >= 1 && c >= 1)
        begin
            val = BORDER_VALUE;
            if (r >= 2 && c >= 2)
            begin
                for (int k = 0; k < 6; k++)
                    hood[k] = window_pix[k];
                hood[6] = up;
                hood[7] = mid;
                hood[8] = item.pixel_in;
                val     = median_of_nine(hood);
            end
            run[n] = position_result(r - 1, c - 1, val);
            n++;
        end
        // Last column of the row above
        if (r >= 1 && c == w - 1)
        begin
            run[n] = position_result(r - 1, w - 1, BORDER_VALUE);
            n++;
        end
        // Bottom row releases itself
        if (r == h - 1)
        begin
            run[n] = position_result(r, c, BORDER_VALUE);
            n++;
        end
        if (n > 0)
            run[n-1].last_of_run = 1'b1;
        for (int k = 0; k < n; k++)
            expected_pixels.push_back(run[k]);

        // Shift the window and update the line stores
        for (int k = 0; k < 3; k++)
            window_pix[k] = window_pix[k+3];
        window_pix[3]  = up;
        window_pix[4]  = mid;
        window_pix[5]  = item.pixel_in;
        upper_line[c]  = mid;
        middle_line[c] = item.pixel_in;

        c++;
        if (c >= w)
        begin
            c = 0;
            r++;
            if (r >= h)
                r = 0;
        end
        cur_col = c;
        cur_row = r;
    endfunction

    function automatic void queue_pixel(logic [PIXEL_BITS-1:0] value, bit start);
        pix_in_t item;
        item.pixel_in    = value;
        item.frame_start = start;
        predict_pixel(item);
        pixel_queue.push_back(item);
    endfunction

    // Mix full-range values, a tight band (many ties) and the two extremes
    function automatic logic [PIXEL_BITS-1:0] pick_pixel();
        case (pixel_style_t'($urandom_range(0, 2)))
            PIX_CLUSTER: return PIXEL_BITS'($urandom_range(120, 124));
            PIX_EXTREME: return $urandom_range(0, 1) ? {PIXEL_BITS{1'b1}} : '0;
            default:     return PIXEL_BITS'($urandom);
        endcase
    endfunction

    function automatic void note_failure(string what);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%0t ns: %s", $time, what);
    endfunction

    // ------------------------------------------------------------------------
    // Configuration writes, only issued while the block is idle
    // ------------------------------------------------------------------------
    task automatic cfg_write(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        // Hold until the register write is accepted
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_FRAME_WIDTH)
            width_raw = value;
        else
            height_raw = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Wait until every queued pixel is transferred and every result is back,
    // then let the pipeline settle in case the last pixel released nothing
    task automatic drain_stream();
        while (pixel_queue.size() != 0 || pix_valid || expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One setting of the frame size followed by a run of random pixels.
    // The first pixel carries frame_start when restart is set; later ones get
    // it at random (start_rate per thousand) to break frames mid-way.
    task automatic run_phase(int w_raw, int h_raw, int count, bit restart, int start_rate);
        drain_stream();
        cfg_write(CFG_FRAME_WIDTH, CFG_DATA_BITS'(w_raw));
        cfg_write(CFG_FRAME_HEIGHT, CFG_DATA_BITS'(h_raw));
        for (int k = 0; k < count; k++)
        begin
            if (k == 0)
                queue_pixel(pick_pixel(), restart);
            else
                queue_pixel(pick_pixel(), $urandom_range(0, 999) < start_rate);
        end
    endtask

    // ------------------------------------------------------------------------
    // Pixel driver: bursts of random length separated by random gaps.
    // A gap of zero chains bursts into long stretches without idling.
    // ------------------------------------------------------------------------
    int burst_left = 1;
    int gap_left   = 0;

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid  <= 1'b0;
            burst_left <= 1;
            gap_left   <= 0;
        end
        else if (!pix_valid || pix_fire)
        begin
            // Previous transfer done (or nothing offered): advance
            if (gap_left > 0)
            begin
                pix_valid <= 1'b0;
                gap_left  <= gap_left - 1;
            end
            else if (pixel_queue.size() > 0)
            begin
                pix_data  <= pixel_queue.pop_front();
                pix_valid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 30);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                pix_valid <= 1'b0;
        end
        // otherwise hold the stalled pixel as it is
    end

    // ------------------------------------------------------------------------
    // Result stall: the style is picked at random from none, random, a fixed
    // comb and long stretches of stall
    // ------------------------------------------------------------------------
    int           stall_tick = 0;
    stall_style_t stall_mode = STALL_NONE;

    always @(negedge clk)
    begin
        stall_tick <= stall_tick + 1;
        if (stall_tick % 48 == 0)
            stall_mode <= stall_style_t'($urandom_range(0, 3));
        case (stall_mode)
            STALL_NONE:   res_stall <= 1'b0;
            STALL_RANDOM: res_stall <= ($urandom_range(0, 2) == 0);
            STALL_COMB:   res_stall <= ((stall_tick % 5) < 2);
            default:      res_stall <= ((stall_tick % 16) < 6);
        endcase
    end

    // ------------------------------------------------------------------------
    // Handshake tracking and watchdog: end the run when no transfer of any
    // kind happens for too long
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        pix_fire <= pix_valid && !pix_stall;
        if (!rst_n || (pix_valid && !pix_stall) || (res_valid && !res_stall)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: compare each result transfer with the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        pix_out_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_pixels.size() == 0)
                note_failure($sformatf("unexpected result row %0d col %0d pixel %0d last %0b",
                    res_data.out_row, res_data.out_col, res_data.out_pixel,
                    res_data.last_of_run));
            else
            begin
                want = expected_pixels.pop_front();
                if (res_data.out_row !== want.out_row || res_data.out_col !== want.out_col
                    || res_data.out_pixel !== want.out_pixel
                    || res_data.last_of_run !== want.last_of_run)
                    note_failure($sformatf({"mismatch: expected row %0d col %0d pixel %0d ",
                        "last %0b, got row %0d col %0d pixel %0d last %0b"},
                        want.out_row, want.out_col, want.out_pixel, want.last_of_run,
                        res_data.out_row, res_data.out_col, res_data.out_pixel,
                        res_data.last_of_run));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        logic [PIXEL_BITS-1:0] ramp [18];

        // Two 3x3 frames: alternating extremes, then a mix with a mid-frame restart
        ramp = '{8'd0,   8'd255, 8'd0,   8'd255, 8'd0,   8'd255, 8'd0,   8'd255, 8'd0,
                 8'd255, 8'd255, 8'd0,   8'd255, 8'd128, 8'd1,   8'd254, 8'd0,   8'd127};

        for (int k = 0; k < LINE_DEPTH; k++)
        begin
            upper_line[k]  = '0;
            middle_line[k] = '0;
        end
        for (int k = 0; k < 6; k++)
            window_pix[k] = '0;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // A few pixels at the reset frame size, starting without frame_start
        queue_pixel(8'h00, 1'b0);
        queue_pixel(8'hFF, 1'b0);
        queue_pixel(8'h55, 1'b0);
        queue_pixel(8'hAA, 1'b0);

        // Size values below the minimum clamp to 3x3; the column counter left
        // past the new width wraps to 0. Second frame follows with no start
        // marker and is restarted near its end.
        drain_stream();
        cfg_write(CFG_FRAME_WIDTH, CFG_DATA_BITS'(0));
        cfg_write(CFG_FRAME_HEIGHT, CFG_DATA_BITS'(2));
        for (int k = 0; k < 18; k++)
            queue_pixel(ramp[k], k == 16);

        // Extreme sizes: above the maximum and the exact maximum
        run_phase(8191, 1, 20, 1'b1, 0);
        run_phase(5, 4096, 40, 1'b1, 20);
        run_phase(4096, 8191, 10, 1'b1, 0);

        // Small random frames, 30 pixels each
        repeat (6)
            run_phase($urandom_range(3, 12), $urandom_range(3, 8), 30, 1'b1, 15);

        // Shrink mid-frame: width first (column past the edge), then height
        // (row past the bottom), without restarting the frame
        run_phase(12, 8, 41, 1'b1, 0);
        run_phase(5, 8, 12, 1'b0, 0);
        run_phase(5, 3, 20, 1'b0, 0);

        drain_stream();
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
